>>> hdl/tws_pkg.sv
// Package with shared types and constants for the timing wheel scheduler.
`timescale 1ns / 1ps
package tws_pkg;

    // Task table size and field widths fixed by the port definition.
    localparam int TASK_ENTRIES = 16;
    localparam int ID_W         = 4;
    localparam int DIV_W        = 32;
    localparam int N_W          = 11;
    localparam int CNT_W        = 6;

    // Largest wheel size in use; larger slot counts clamp to it.
    localparam int MAX_SLOTS    = 1024;

    // Request opcodes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_ADDED   = 3'd0;
    localparam logic [2:0] EV_FIRED   = 3'd1;
    localparam logic [2:0] EV_FULL    = 3'd2;
    localparam logic [2:0] EV_CANCEL  = 3'd3;
    localparam logic [2:0] EV_EXPIRED = 3'd4;
    localparam logic [2:0] EV_TICK    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_ROT,
        ST_DIV_SLOT,
        ST_SCAN,
        ST_DIV_TICK,
        ST_EMIT
    } t_state;

endpackage

>>> hdl/timing_wheel_scheduler.sv
// Top level of the hashed timing wheel scheduler with its shared divider.
//
// Usage: one request enters on i_in_valid / o_in_ready with i_opcode,
// i_timeout_ticks and i_cancel_id. Results leave on o_out_valid /
// i_out_ready; o_last_result marks the final result of a request.
// The slot count is written on i_cfg_valid / o_cfg_ready while idle
// and while no request is offered.
// One restoring divider, one quotient bit per cycle, does all modulo work.
// An add with a free entry divides the timeout for the rotation count,
// then reduces the slot, then loads the result; fire, full and cancel go
// straight to the result. A tick scans the 16 entries one per cycle while
// no expiry waits on the result register, then reduces the new current slot.
// Only one request is worked on at a time; o_in_ready is high when idle.
// The result register lets a request be accepted while the last result
// still waits. When the receiver stalls, the tick scan holds on an
// expiring entry until the result register frees up.
// Reset clears all entry valid bits, sets the current slot to zero and
// the slot count to 256.
`timescale 1ns / 1ps
module timing_wheel_scheduler
    import tws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [N_W-1:0]     i_cfg_slot_count,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_timeout_ticks,
    input  logic [ID_W-1:0]    i_cancel_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_event_kind,
    output logic [ID_W-1:0]    o_task_id,
    output logic               o_last_result
);

    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SUMW = ((SW > N_W) ? SW : N_W) + 1;

    // State and payload registers.
    t_state                  r_state, n_state;
    logic [N_W-1:0]          r_slot_count;
    logic [TASK_ENTRIES-1:0] r_valid, n_valid;
    logic [SW-1:0]           r_slot [TASK_ENTRIES];
    logic [DIV_W-1:0]        r_rot  [TASK_ENTRIES];
    logic [SW-1:0]           r_cur, n_cur;
    logic [N_W-1:0]          r_rem, n_rem;
    logic [DIV_W-1:0]        r_quo, n_quo;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [ID_W-1:0]         r_id, n_id;
    logic [2:0]              r_kind, n_kind;
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_ev_kind, n_ev_kind;
    logic [ID_W-1:0]         r_task_id, n_task_id;
    logic                    r_last, n_last;

    // Entry store write controls.
    logic                    slot_we, rot_we;
    logic [SW-1:0]           slot_wdata;
    logic [DIV_W-1:0]        rot_wdata;

    // Combinational helpers.
    logic [N_W-1:0]          w_n;
    logic [N_W:0]            rem_sh;
    logic                    ge;
    logic [N_W-1:0]          rem_nx;
    logic [ID_W-1:0]         free_id;
    logic                    out_free;
    logic                    hit;
    logic [SUMW-1:0]         sum;

    assign o_cfg_ready   = (r_state == ST_IDLE) && !i_in_valid;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_ev_kind;
    assign o_task_id     = r_task_id;
    assign o_last_result = r_last;

    // Effective wheel size: zero acts as one, large values clamp.
    always_comb begin
        if (r_slot_count == '0) begin
            w_n = N_W'(1);
        end else if (32'(r_slot_count) > 32'(MAX_SLOTS)) begin
            w_n = N_W'(MAX_SLOTS);
        end else begin
            w_n = r_slot_count;
        end
    end

    // One restoring divide step.
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, w_n});
    assign rem_nx = ge ? N_W'(rem_sh - {1'b0, w_n}) : rem_sh[N_W-1:0];

    // Lowest free entry.
    always_comb begin
        free_id = '0;
        for (int i = TASK_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_id = ID_W'(i);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign hit      = r_valid[r_id] && (r_slot[r_id] == r_cur);

    // Sequencer: next state, divider control and result loading.
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_cur       = r_cur;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_id        = r_id;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ev_kind   = r_ev_kind;
        n_task_id   = r_task_id;
        n_last      = r_last;
        slot_we     = 1'b0;
        rot_we      = 1'b0;
        slot_wdata  = SW'(rem_nx);
        rot_wdata   = {r_quo[DIV_W-2:0], ge};
        sum         = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_ADD: begin
                            if (i_timeout_ticks[31]) begin
                                n_kind  = EV_FIRED;
                                n_id    = '0;
                                n_state = ST_EMIT;
                            end else if (&r_valid) begin
                                n_kind  = EV_FULL;
                                n_id    = '0;
                                n_state = ST_EMIT;
                            end else begin
                                n_id    = free_id;
                                n_quo   = i_timeout_ticks;
                                n_rem   = '0;
                                n_cnt   = CNT_W'(DIV_W);
                                n_state = ST_DIV_ROT;
                            end
                        end
                        OP_CANCEL: begin
                            n_valid[i_cancel_id] = 1'b0;
                            n_kind  = EV_CANCEL;
                            n_id    = i_cancel_id;
                            n_state = ST_EMIT;
                        end
                        OP_TICK: begin
                            n_id    = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV_ROT: begin
                n_rem = rem_nx;
                n_quo = {r_quo[DIV_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    // Quotient is the rotation count; now reduce the slot.
                    rot_we  = 1'b1;
                    sum     = SUMW'(r_cur) + SUMW'(rem_nx);
                    n_quo   = {sum, {(DIV_W-SUMW){1'b0}}};
                    n_rem   = '0;
                    n_cnt   = CNT_W'(SUMW);
                    n_state = ST_DIV_SLOT;
                end
            end
            ST_DIV_SLOT: begin
                n_rem = rem_nx;
                n_quo = {r_quo[DIV_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    slot_we        = 1'b1;
                    n_valid[r_id]  = 1'b1;
                    n_kind         = EV_ADDED;
                    n_state        = ST_EMIT;
                end
            end
            ST_SCAN: begin
                // Visit one entry per cycle; hold while an expiry waits.
                if (hit && r_rot[r_id] != '0) begin
                    rot_we    = 1'b1;
                    rot_wdata = r_rot[r_id] - 1'b1;
                end
                if (!(hit && r_rot[r_id] == '0 && !out_free)) begin
                    if (hit && r_rot[r_id] == '0) begin
                        n_valid[r_id] = 1'b0;
                        n_out_valid   = 1'b1;
                        n_ev_kind     = EV_EXPIRED;
                        n_task_id     = r_id;
                        n_last        = 1'b0;
                    end
                    n_id = r_id + 1'b1;
                    if (r_id == ID_W'(TASK_ENTRIES - 1)) begin
                        sum     = SUMW'(r_cur) + SUMW'(1);
                        n_quo   = {sum, {(DIV_W-SUMW){1'b0}}};
                        n_rem   = '0;
                        n_cnt   = CNT_W'(SUMW);
                        n_state = ST_DIV_TICK;
                    end
                end
            end
            ST_DIV_TICK: begin
                n_rem = rem_nx;
                n_quo = {r_quo[DIV_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_cur   = SW'(rem_nx);
                    n_kind  = EV_TICK;
                    n_id    = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ev_kind   = r_kind;
                    n_task_id   = r_id;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_count <= N_W'(256);
            r_valid      <= '0;
            r_cur        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slot_count <= i_cfg_slot_count;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_id      <= n_id;
        r_kind    <= n_kind;
        r_ev_kind <= n_ev_kind;
        r_task_id <= n_task_id;
        r_last    <= n_last;
    end

    // Entry slot and rotation stores.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot[r_id] <= slot_wdata;
        end
        if (rot_we) begin
            r_rot[r_id] <= rot_wdata;
        end
    end

endmodule

>>> tb/timing_wheel_scheduler_test.sv
// Self-checking testbench for the timing wheel scheduler: adds, cancels and ticks.
`timescale 1ns / 1ps
module timing_wheel_scheduler_test;
    import tws_pkg::*;

    // Opcode that the block ignores.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_OFF_LEN = 300;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_event;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [N_W-1:0]     i_cfg_slot_count;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_timeout_ticks;
    logic [ID_W-1:0]    i_cancel_id;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_event_kind;
    logic [ID_W-1:0]    o_task_id;
    logic               o_last_result;

    // Shadow copy of the wheel state.
    logic [N_W-1:0] shadow_slot_count;
    logic           shadow_valid [TASK_ENTRIES];
    logic [9:0]     shadow_slot [TASK_ENTRIES];
    logic [31:0]    shadow_rot [TASK_ENTRIES];
    logic [9:0]     shadow_current;

    t_event pending_events [$];
    int     mismatch_count;
    int     recv_idle_pct;
    int     hold_off_requests = 0;
    int     hold_off_served = 0;
    int     hold_off_cycles = 0;

    timing_wheel_scheduler dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Limit on run time.
    initial begin
        #60ms;
        $display("timing_wheel_scheduler_test: FAIL");
        $finish;
    end

    function automatic logic [31:0] wheel_size();
        logic [31:0] n;
        n = shadow_slot_count;
        if (n == 0) n = 1;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return n;
    endfunction

    function automatic void push_event(logic [2:0] kind, logic [ID_W-1:0] id, logic last);
        t_event ev;
        ev.kind = kind;
        ev.id = id;
        ev.last = last;
        pending_events = {pending_events, ev};
    endfunction

    // Work out the events one request causes and update the shadow state.
    function automatic void predict_events(logic [1:0] op, logic [31:0] raw,
                                           logic [ID_W-1:0] cid);
        logic [31:0] n;
        int free_idx;
        n = wheel_size();
        free_idx = -1;
        case (op)
            OP_ADD: begin
                if (raw[31]) begin
                    push_event(EV_FIRED, '0, 1'b1);
                end else begin
                    for (int i = TASK_ENTRIES - 1; i >= 0; i--)
                        if (!shadow_valid[i]) free_idx = i;
                    if (free_idx < 0) begin
                        push_event(EV_FULL, '0, 1'b1);
                    end else begin
                        shadow_valid[free_idx] = 1'b1;
                        shadow_slot[free_idx] = 10'((64'(shadow_current) + 64'(raw % n)) % n);
                        shadow_rot[free_idx] = raw / n;
                        push_event(EV_ADDED, ID_W'(free_idx), 1'b1);
                    end
                end
            end
            OP_CANCEL: begin
                shadow_valid[cid] = 1'b0;
                push_event(EV_CANCEL, cid, 1'b1);
            end
            OP_TICK: begin
                for (int i = 0; i < TASK_ENTRIES; i++) begin
                    if (shadow_valid[i] && shadow_slot[i] == shadow_current) begin
                        if (shadow_rot[i] > 0) begin
                            shadow_rot[i]--;
                        end else begin
                            shadow_valid[i] = 1'b0;
                            push_event(EV_EXPIRED, ID_W'(i), 1'b0);
                        end
                    end
                end
                shadow_current = 10'((32'(shadow_current) + 1) % n);
                push_event(EV_TICK, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // Send one request, with a random gap before it unless no_gap is set; valid drops only in a gap.
    task automatic send_request(logic [1:0] op, logic [31:0] raw, logic [ID_W-1:0] cid,
                                bit no_gap = 0);
        while (!no_gap && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_timeout_ticks <= raw;
        i_cancel_id <= cid;
        do @(posedge i_clk); while (!o_in_ready);
        predict_events(op, raw, cid);
    endtask

    // Wait until all expected events have arrived, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_slot_count(logic [N_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_slot_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_slot_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Check each result against the oldest expected event.
    always @(posedge i_clk) begin
        t_event exp_ev;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d id=%0d last=%0d",
                             o_event_kind, o_task_id, o_last_result);
            end else begin
                exp_ev = pending_events.pop_front();
                if (o_event_kind !== exp_ev.kind || o_task_id !== exp_ev.id
                        || o_last_result !== exp_ev.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d id=%0d last=%0d, got %0d %0d %0d",
                                 exp_ev.kind, exp_ev.id, exp_ev.last,
                                 o_event_kind, o_task_id, o_last_result);
                end
            end
        end
    end

    // Receiver ready, with random stalls and a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_off_requests != hold_off_served) begin
            hold_off_served <= hold_off_requests;
            hold_off_cycles <= HOLD_OFF_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed_edges();
        write_slot_count(11'd4);
        send_request(OP_ADD, 32'h8000_0000, 4'd0);
        send_request(OP_ADD, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_ADD, 32'd0, 4'd0);
        send_request(OP_ADD, 32'd5, 4'd0);
        send_request(OP_ADD, 32'h7FFF_FFFF, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
        send_request(OP_CANCEL, 32'd0, 4'd2);
        send_request(OP_CANCEL, 32'd0, 4'd15);
        send_request(OP_UNUSED, 32'd0, 4'd0);
        // Fill the table, then two more adds report it full.
        for (int i = 0; i < 17; i++) send_request(OP_ADD, 32'd0, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
    endtask

    task automatic test_slot_count_extremes();
        write_slot_count(11'd0);
        send_request(OP_ADD, 32'd3, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
        write_slot_count(11'd2047);
        send_request(OP_ADD, 32'd1500, 4'd0);
        send_request(OP_TICK, 32'd0, 4'd0);
        write_slot_count(11'd1024);
        send_request(OP_ADD, 32'd1023, 4'd0);
        write_slot_count(11'd1);
        send_request(OP_TICK, 32'd0, 4'd0);
    endtask

    task automatic random_mix(int count);
        logic [1:0] op;
        logic [31:0] raw;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            op = sel < 45 ? OP_ADD : sel < 60 ? OP_CANCEL : sel < 98 ? OP_TICK : OP_UNUSED;
            case ($urandom_range(3))
                0: raw = $urandom;
                1: raw = $urandom_range(40);
                default: raw = $urandom_range(3 * 8);
            endcase
            send_request(op, raw, 4'($urandom));
        end
    endtask

    task automatic test_random_settings();
        write_slot_count(11'd8);
        random_mix(120);
        write_slot_count(11'd3);
        random_mix(100);
        // Long stretch with no idling on either side.
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            send_request($urandom_range(1) ? OP_ADD : OP_TICK, $urandom_range(12), 4'($urandom), 1);
        recv_idle_pct = 21;
        write_slot_count(11'($urandom_range(2, 1024)));
        random_mix(60);
    endtask

    task automatic test_back_pressure();
        write_slot_count(11'd2);
        @(posedge i_clk);
        hold_off_requests++;
        for (int i = 0; i < 12; i++)
            send_request(i % 3 == 2 ? OP_TICK : OP_ADD, 32'(i % 4), 4'd0, 1);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_slot_count = '0;
        i_in_valid = 1'b0;
        i_opcode = '0;
        i_timeout_ticks = '0;
        i_cancel_id = '0;
        mismatch_count = 0;
        recv_idle_pct = 21;
        shadow_slot_count = 11'd256;
        shadow_current = '0;
        for (int i = 0; i < TASK_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_slot[i] = '0;
            shadow_rot[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_slot_count_extremes();
        test_back_pressure();
        test_random_settings();
        drain();

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("timing_wheel_scheduler_test: PASS");
        else
            $display("timing_wheel_scheduler_test: FAIL");
        $finish;
    end
endmodule
